FILE: rtl/u8vc_pkg.sv
// Shared types, constants and lookup functions for the UTF-8 validating counter.
// Holds the byte-class ROM, the DFA transition table and the encoded-length function.
// No dependencies.
package u8vc_pkg;

  // Default width of the internal codepoint and size counters
  localparam int COUNT_WIDTH_DEF = 32;

  // Width of the result count fields
  localparam int OUT_WIDTH = 32;

  // Partial codepoint width
  localparam int CODE_WIDTH = 21;

  // DFA state codes: 0 accept, 1 reject, 2..8 inside a character
  typedef logic [3:0] dfa_state_t;
  typedef logic [3:0] byte_class_t;

  localparam dfa_state_t ST_ACCEPT = 4'd0;
  localparam dfa_state_t ST_REJECT = 4'd1;
  localparam dfa_state_t ST_LAST   = 4'd8;

  // Transition table, indexed by [state][byte class]
  localparam dfa_state_t NEXT_STATE [0:8][0:15] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1,
      4'd1, 4'd1, 4'd4, 4'd6, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0,
      4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
      4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
      4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
      4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
  };

  // Byte class ROM
  function automatic byte_class_t byte_class(input logic [7:0] b);
    byte_class_t cls;
    if (b <= 8'h7F)      cls = 4'd0;
    else if (b <= 8'h8F) cls = 4'd1;
    else if (b <= 8'h9F) cls = 4'd9;
    else if (b <= 8'hBF) cls = 4'd7;
    else if (b <= 8'hC1) cls = 4'd8;
    else if (b <= 8'hDF) cls = 4'd2;
    else if (b == 8'hE0) cls = 4'd10;
    else if (b == 8'hED) cls = 4'd4;
    else if (b <= 8'hEF) cls = 4'd3;
    else if (b == 8'hF0) cls = 4'd11;
    else if (b <= 8'hF3) cls = 4'd6;
    else if (b == 8'hF4) cls = 4'd5;
    else                 cls = 4'd8;
    return cls;
  endfunction

  // UTF-8 encoded length of a codepoint, 1 to 4
  function automatic logic [2:0] utf8_len(input logic [CODE_WIDTH-1:0] code);
    logic [2:0] len;
    if (code <= 21'h00007F)      len = 3'd1;
    else if (code <= 21'h0007FF) len = 3'd2;
    else if (code <= 21'h00FFFF) len = 3'd3;
    else                         len = 3'd4;
    return len;
  endfunction

endpackage

FILE: rtl/utf8_validating_counter_unit.sv
// UTF-8 validating counter, top level.
// Uses u8vc_pkg for the byte-class ROM, the DFA table and the length function.
//
// Usage:
//   Input channel (in_valid/in_stall): one string byte per word in in_byte,
//   with last_byte high on the final byte of the string.
//   Output channel (out_valid/out_stall): one word per string, carrying
//   status (0 valid, 1 invalid or truncated), codepoint_count and
//   encoded_size. Trailing zero bytes are excluded from both counts; an
//   invalid string reports zero counts. Counts saturate at their maximum.
// Timing:
//   One byte is accepted every cycle while in_stall is low. The DFA step,
//   counter updates and final count correction sit between the state and
//   result registers; a result appears the cycle after its last byte is taken.
// Stall:
//   The result register holds while out_stall is high. Non-final bytes keep
//   flowing meanwhile; only a final byte is held off (in_stall high) while
//   an earlier result still waits in the result register.
// Reset:
//   rst (synchronous) returns the DFA to accept, clears all counters and
//   empties the result register. State also returns to reset after every
//   final byte, ready for the next string.
module utf8_validating_counter_unit
  import u8vc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  input  logic                 last_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 status,
  output logic [OUT_WIDTH-1:0] codepoint_count,
  output logic [OUT_WIDTH-1:0] encoded_size
);

  localparam int EXT_WIDTH = (COUNT_WIDTH > OUT_WIDTH) ? COUNT_WIDTH : OUT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Stream state
  dfa_state_t             dfa_state;
  logic [CODE_WIDTH-1:0]  partial_code;
  logic [COUNT_WIDTH-1:0] char_count;
  logic [COUNT_WIDTH-1:0] size_total;
  logic [COUNT_WIDTH-1:0] zero_run;

  dfa_state_t             dfa_state_next;
  logic [CODE_WIDTH-1:0]  partial_code_next;
  logic [COUNT_WIDTH-1:0] char_count_next;
  logic [COUNT_WIDTH-1:0] size_total_next;
  logic [COUNT_WIDTH-1:0] zero_run_next;

  logic                   in_take;
  byte_class_t            cls;
  dfa_state_t             st_cur;
  logic                   was_accept;
  logic                   now_accept;
  logic [COUNT_WIDTH:0]   char_sum;
  logic [COUNT_WIDTH:0]   size_sum;
  logic [COUNT_WIDTH:0]   run_sum;
  logic [COUNT_WIDTH-1:0] char_fin;
  logic [COUNT_WIDTH-1:0] size_fin;
  logic [EXT_WIDTH-1:0]   char_ext;
  logic [EXT_WIDTH-1:0]   size_ext;

  // Handshake: only a final byte waits for the result register
  assign in_stall = out_valid & out_stall & last_byte;
  assign in_take  = in_valid & ~in_stall;

  // DFA step and partial codepoint
  always_comb begin
    cls        = byte_class(in_byte);
    st_cur     = (dfa_state <= ST_LAST) ? dfa_state : ST_REJECT;
    was_accept = (st_cur == ST_ACCEPT);
    if (was_accept) begin
      partial_code_next = CODE_WIDTH'((8'hFF >> cls) & in_byte);
    end else begin
      partial_code_next = {partial_code[CODE_WIDTH-7:0], in_byte[5:0]};
    end
    dfa_state_next = NEXT_STATE[st_cur][cls];
    now_accept     = (dfa_state_next == ST_ACCEPT);
  end

  // Saturating counters, updated on each completed character
  always_comb begin
    char_sum = {1'b0, char_count} + (COUNT_WIDTH+1)'(1);
    size_sum = {1'b0, size_total} + (COUNT_WIDTH+1)'(utf8_len(partial_code_next));
    run_sum  = {1'b0, zero_run} + (COUNT_WIDTH+1)'(1);
    char_count_next = char_count;
    size_total_next = size_total;
    zero_run_next   = zero_run;
    if (now_accept) begin
      char_count_next = char_sum[COUNT_WIDTH] ? COUNT_MAX : char_sum[COUNT_WIDTH-1:0];
      size_total_next = size_sum[COUNT_WIDTH] ? COUNT_MAX : size_sum[COUNT_WIDTH-1:0];
      if (was_accept && (in_byte == 8'h00)) begin
        zero_run_next = run_sum[COUNT_WIDTH] ? COUNT_MAX : run_sum[COUNT_WIDTH-1:0];
      end else begin
        zero_run_next = '0;
      end
    end
  end

  // Final counts: drop the trailing zero run unless saturated
  always_comb begin
    if (char_count_next == COUNT_MAX) begin
      char_fin = COUNT_MAX;
    end else if (char_count_next >= zero_run_next) begin
      char_fin = char_count_next - zero_run_next;
    end else begin
      char_fin = '0;
    end
    if (size_total_next == COUNT_MAX) begin
      size_fin = COUNT_MAX;
    end else if (size_total_next >= zero_run_next) begin
      size_fin = size_total_next - zero_run_next;
    end else begin
      size_fin = '0;
    end
    char_ext = EXT_WIDTH'(char_fin);
    size_ext = EXT_WIDTH'(size_fin);
  end

  // Stream state registers, back to reset after each final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      dfa_state    <= ST_ACCEPT;
      partial_code <= '0;
      char_count   <= '0;
      size_total   <= '0;
      zero_run     <= '0;
    end else if (in_take) begin
      if (last_byte) begin
        dfa_state    <= ST_ACCEPT;
        partial_code <= '0;
        char_count   <= '0;
        size_total   <= '0;
        zero_run     <= '0;
      end else begin
        dfa_state    <= dfa_state_next;
        partial_code <= partial_code_next;
        char_count   <= char_count_next;
        size_total   <= size_total_next;
        zero_run     <= zero_run_next;
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take && last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (in_take && last_byte) begin
      if (now_accept) begin
        status          <= 1'b0;
        codepoint_count <= char_ext[OUT_WIDTH-1:0];
        encoded_size    <= size_ext[OUT_WIDTH-1:0];
      end else begin
        status          <= 1'b1;
        codepoint_count <= '0;
        encoded_size    <= '0;
      end
    end
  end

endmodule

FILE: rtl/u8vc_checker.sv
// Port-level checker for the UTF-8 validating counter, with its bind.
// Uses u8vc_pkg for the result field width; attaches to utf8_validating_counter_unit.
module u8vc_checker
  import u8vc_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [7:0]           in_byte,
  input logic                 last_byte,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 status,
  input logic [OUT_WIDTH-1:0] codepoint_count,
  input logic [OUT_WIDTH-1:0] encoded_size
);

  // A final byte taken yields a result word on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_byte |=> out_valid)
    else $error("final byte accepted without a result word");

  // An invalid string reports zero counts
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (codepoint_count == '0) && (encoded_size == '0))
    else $error("invalid result carries nonzero counts");

  // Every codepoint needs at least one byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> encoded_size >= codepoint_count)
    else $error("encoded size below codepoint count");

  // A stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status)
      && $stable(codepoint_count) && $stable(encoded_size))
    else $error("stalled result word changed");

  // Reset empties the result register
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind utf8_validating_counter_unit u8vc_checker u8vc_checker_i (.*);

FILE: tb/sv/testbench.sv
// Self-checking testbench for utf8_validating_counter_unit.
// Feeds UTF-8 strings one byte per word, predicts status and counts per string, checks results.
// Depends on u8vc_pkg and the RTL top level only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import u8vc_pkg::*;

  localparam int STALL_HOLD   = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam logic [63:0] CNT_MAX = 64'h0000_0000_FFFF_FFFF;

  // Validating DFA transitions, [state][byte class]
  localparam dfa_state_t DFA_NEXT [0:8][0:15] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
  };

  typedef struct packed {
    logic        status;
    logic [31:0] chars;
    logic [31:0] bytes;
  } string_tally_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall;
  logic        status;
  logic [31:0] codepoint_count;
  logic [31:0] encoded_size;

  int          gap_pct;
  int          stall_pct;
  bit          hold_req;
  logic [7:0]  str_bytes [$];

  utf8_validating_counter_unit u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .last_byte       (last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .codepoint_count (codepoint_count),
    .encoded_size    (encoded_size)
  );

  // Byte class used to index the DFA
  function automatic byte_class_t class_of(input logic [7:0] b);
    if (b < 8'h80) return 4'd0;
    if (b < 8'h90) return 4'd1;
    if (b < 8'hA0) return 4'd9;
    if (b < 8'hC0) return 4'd7;
    if (b < 8'hC2) return 4'd8;
    if (b < 8'hE0) return 4'd2;
    if (b == 8'hE0) return 4'd10;
    if (b == 8'hED) return 4'd4;
    if (b < 8'hF0) return 4'd3;
    if (b == 8'hF0) return 4'd11;
    if (b < 8'hF4) return 4'd6;
    if (b == 8'hF4) return 4'd5;
    return 4'd8;
  endfunction

  // Bytes needed to re-encode a codepoint
  function automatic logic [63:0] enc_bytes(input logic [20:0] cp);
    if (cp < 21'h80) return 64'd1;
    if (cp < 21'h800) return 64'd2;
    if (cp < 21'h10000) return 64'd3;
    return 64'd4;
  endfunction

  function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
    if (a >= CNT_MAX || b > CNT_MAX - a) return CNT_MAX;
    return a + b;
  endfunction

  // Saturated counts are reported as is; otherwise trailing nulls come off
  function automatic logic [31:0] trim_nulls(input logic [63:0] c, input logic [63:0] run);
    if (c >= CNT_MAX) return CNT_MAX[31:0];
    if (c >= run) return 32'(c - run);
    return 32'd0;
  endfunction

  // Per-string decoder state and the queue of tallies still owed by the block
  class utf8_tally;
    dfa_state_t    st;
    logic [20:0]   code;
    logic [63:0]   chars;
    logic [63:0]   size;
    logic [63:0]   null_run;
    string_tally_t owed [$];
    int            errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      st       = ST_ACCEPT;
      code     = '0;
      chars    = '0;
      size     = '0;
      null_run = '0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Advance the decoder by one accepted byte
    function void note_byte(input logic [7:0] b, input logic fin);
      byte_class_t   cls;
      dfa_state_t    cur;
      logic          from_accept;
      string_tally_t t;
      cls = class_of(b);
      cur = (st <= ST_LAST) ? st : ST_REJECT;
      from_accept = (cur == ST_ACCEPT);
      if (from_accept) code = {13'd0, b & (8'hFF >> cls)};
      else code = {code[14:0], b[5:0]};
      cur = DFA_NEXT[cur][cls];
      st = cur;
      if (cur == ST_ACCEPT) begin
        chars = sat_sum(chars, 64'd1);
        size  = sat_sum(size, enc_bytes(code));
        if (from_accept && b == 8'h00) null_run = sat_sum(null_run, 64'd1);
        else null_run = '0;
      end
      if (fin) begin
        if (cur != ST_ACCEPT) t = '{status: 1'b1, chars: 32'd0, bytes: 32'd0};
        else t = '{status: 1'b0, chars: trim_nulls(chars, null_run),
                   bytes: trim_nulls(size, null_run)};
        owed.push_back(t);
        clear();
      end
    endfunction

    // Compare one result word against the oldest owed tally
    function void check_result(input logic s, input logic [31:0] c, input logic [31:0] n);
      string_tally_t t;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result status=%0d count=%0d size=%0d", $time, s, c, n);
        errors++;
        return;
      end
      t = owed.pop_front();
      if (s !== t.status) begin
        $display("%0t: status expected %0d, got %0d", $time, t.status, s);
        errors++;
      end
      if (c !== t.chars) begin
        $display("%0t: codepoint_count expected %0d, got %0d", $time, t.chars, c);
        errors++;
      end
      if (n !== t.bytes) begin
        $display("%0t: encoded_size expected %0d, got %0d", $time, t.bytes, n);
        errors++;
      end
    endfunction
  endclass

  utf8_tally tally;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Input and output monitors
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) tally.note_byte(in_byte, last_byte);
    if (!rst && out_valid && !out_stall) tally.check_result(status, codepoint_count, encoded_size);
  end

  // Receiver: random stall, or one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (STALL_HOLD - 1) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("utf8_validating_counter_unit test failed");
    $finish;
  end

  // Offer one byte and wait until it is taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_byte   <= b;
    last_byte <= fin;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_string();
    foreach (str_bytes[i]) send_byte(str_bytes[i], i == str_bytes.size() - 1);
  endtask

  // Drop valid and hold the sender until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tally.pending() != 0) @(posedge clk);
  endtask

  // Append the UTF-8 form of a codepoint
  function automatic void push_char(input logic [20:0] cp);
    if (cp < 21'h80) begin
      str_bytes.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      str_bytes.push_back({3'b110, cp[10:6]});
      str_bytes.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      str_bytes.push_back({4'b1110, cp[15:12]});
      str_bytes.push_back({2'b10, cp[11:6]});
      str_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      str_bytes.push_back({5'b11110, cp[20:18]});
      str_bytes.push_back({2'b10, cp[17:12]});
      str_bytes.push_back({2'b10, cp[11:6]});
      str_bytes.push_back({2'b10, cp[5:0]});
    end
  endfunction

  // Random scalar value of random encoded length, with some nulls
  function automatic logic [20:0] rand_scalar();
    logic [20:0] cp;
    if ($urandom_range(0, 9) == 0) return 21'd0;
    case ($urandom_range(0, 3))
      0: cp = 21'($urandom_range(0, 'h7F));
      1: cp = 21'($urandom_range('h80, 'h7FF));
      2: begin
        do cp = 21'($urandom_range('h800, 'hFFFF));
        while (cp >= 21'hD800 && cp <= 21'hDFFF);
      end
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    return cp;
  endfunction

  function automatic logic [7:0] cont_byte(input int lo, input int hi);
    return 8'($urandom_range(lo, hi));
  endfunction

  // Build one random string: mostly well formed, some broken, some noise
  function automatic void build_string(input int max_chars);
    int kind;
    int n;
    int pos;
    str_bytes.delete();
    kind = $urandom_range(0, 99);
    n = $urandom_range(1, max_chars);
    if (kind >= 85) begin
      repeat (n) str_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat (n) push_char(rand_scalar());
    if (kind >= 65) begin
      case ($urandom_range(0, 6))
        0: begin
          // lead byte whose character is cut short
          case ($urandom_range(0, 2))
            0: str_bytes.push_back(cont_byte('hC2, 'hDF));
            1: begin
              str_bytes.push_back(cont_byte('hE1, 'hEC));
              if ($urandom_range(0, 1)) str_bytes.push_back(cont_byte('h80, 'hBF));
            end
            default: begin
              str_bytes.push_back(cont_byte('hF1, 'hF3));
              str_bytes.push_back(cont_byte('h80, 'hBF));
              str_bytes.push_back(cont_byte('h80, 'hBF));
            end
          endcase
          return;
        end
        1: begin
          if ($urandom_range(0, 1)) str_bytes.push_back(cont_byte('hC0, 'hC1));
          else str_bytes.push_back(cont_byte('hF5, 'hFF));
          str_bytes.push_back(cont_byte('h80, 'hBF));
        end
        2: begin
          // surrogate range
          str_bytes.push_back(8'hED);
          str_bytes.push_back(cont_byte('hA0, 'hBF));
          str_bytes.push_back(cont_byte('h80, 'hBF));
        end
        3: begin
          // overlong three or four byte forms
          if ($urandom_range(0, 1)) begin
            str_bytes.push_back(8'hE0);
            str_bytes.push_back(cont_byte('h80, 'h9F));
          end else begin
            str_bytes.push_back(8'hF0);
            str_bytes.push_back(cont_byte('h80, 'h8F));
            str_bytes.push_back(cont_byte('h80, 'hBF));
          end
          str_bytes.push_back(cont_byte('h80, 'hBF));
        end
        4: begin
          // above the last scalar value
          str_bytes.push_back(8'hF4);
          str_bytes.push_back(cont_byte('h90, 'hBF));
          str_bytes.push_back(cont_byte('h80, 'hBF));
          str_bytes.push_back(cont_byte('h80, 'hBF));
        end
        5: str_bytes.push_back(cont_byte('h80, 'hBF));
        default: begin
          pos = $urandom_range(0, str_bytes.size() - 1);
          str_bytes[pos] = 8'($urandom_range(0, 255));
        end
      endcase
      repeat ($urandom_range(0, 2)) push_char(rand_scalar());
    end
    // trailing nulls
    if ($urandom_range(0, 99) < 30) repeat ($urandom_range(1, 3)) str_bytes.push_back(8'h00);
  endfunction

  task automatic run_random(input int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      build_string(6);
      send_string();
      sent += str_bytes.size();
    end
  endtask

  // Stimulus
  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_byte   <= 8'h00;
    last_byte <= 1'b0;
    gap_pct   = 0;
    stall_pct = 0;
    hold_req  = 1'b0;
    tally = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed strings
    str_bytes = '{8'h41};                      send_string();
    str_bytes = '{8'h00};                      send_string();
    str_bytes = '{8'hC3, 8'hA9};               send_string();
    str_bytes = '{8'hE2, 8'h82, 8'hAC};        send_string();
    str_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80}; send_string();
    str_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; send_string();
    str_bytes = '{8'hE2, 8'h82};               send_string();
    str_bytes = '{8'h80, 8'hFF};               send_string();
    str_bytes = '{8'h41, 8'h00, 8'h00};        send_string();
    str_bytes = '{8'h7F};                      send_string();
    drain_results();

    // Random strings under each idling mix
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 87; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 87; end
        default: begin gap_pct = 34; stall_pct = 34; end
      endcase
      run_random(125);
      drain_results();
    end

    // Long receiver hold-off while short strings keep coming
    gap_pct   = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    repeat (8) begin
      build_string(2);
      send_string();
    end
    drain_results();

    repeat (10) @(posedge clk);
    if (tally.errors == 0 && tally.pending() == 0) begin
      $display("utf8_validating_counter_unit test passed");
    end else begin
      if (tally.pending() != 0) $display("%0t: %0d results never arrived", $time, tally.pending());
      $display("utf8_validating_counter_unit test failed");
    end
    $finish;
  end

endmodule
